/* sv/crd_pkg.sv */
// Package for the connection retry deadline block.
// Holds the transaction structs, phase and event codes and register reset values.
// No dependencies.
package crd_pkg;

  // Connection phases.
  typedef enum logic [2:0] {
    PH_READY      = 3'd0,
    PH_CONNECTING = 3'd1,
    PH_AWAITING   = 3'd2,
    PH_CONNECTED  = 3'd3,
    PH_WAITING    = 3'd4
  } phase_e;

  // Event codes carried by an input transaction.
  typedef enum logic [2:0] {
    FN_QUERY     = 3'd0,
    FN_ATTEMPT   = 3'd1,
    FN_TRANSPORT = 3'd2,
    FN_ALIVE     = 3'd3,
    FN_READY     = 3'd4,
    FN_FAILED    = 3'd5
  } func_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_DELAY     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CONNECT_TIMEOUT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_APP_TIMEOUT     = 2'd2;

  localparam logic [31:0] RETRY_DELAY_RST     = 32'd1000;
  localparam logic [31:0] CONNECT_TIMEOUT_RST = 32'd5000;
  localparam logic [31:0] APP_TIMEOUT_RST     = 32'd10000;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] now_time;
  } crd_in_t;

  typedef struct packed {
    logic [2:0]  phase_now;
    logic        may_start;
    logic        attempt_expired;
    logic        application_expired;
    logic [31:0] wait_left;
  } crd_out_t;

  // Configuration values handed from the register file to the core.
  typedef struct packed {
    logic [31:0] retry_delay;
    logic [31:0] connect_timeout;
    logic [31:0] application_timeout;
  } crd_cfg_t;

endpackage

/* sv/crd_cfg_regs.sv */
// Configuration register file of the connection retry deadline block.
// Depends on crd_pkg.
module crd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [crd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                  cfg_wdata_i,
  output crd_pkg::crd_cfg_t            cfg_o
);

  crd_pkg::crd_cfg_t cfg_q;

  // Writes to an index beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_delay         <= crd_pkg::RETRY_DELAY_RST;
      cfg_q.connect_timeout     <= crd_pkg::CONNECT_TIMEOUT_RST;
      cfg_q.application_timeout <= crd_pkg::APP_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        crd_pkg::CFG_RETRY_DELAY:     cfg_q.retry_delay         <= cfg_wdata_i;
        crd_pkg::CFG_CONNECT_TIMEOUT: cfg_q.connect_timeout     <= cfg_wdata_i;
        crd_pkg::CFG_APP_TIMEOUT:     cfg_q.application_timeout <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/crd_core.sv */
// Phase and deadline state machine of the connection retry deadline block.
// Applies one event per cycle while fire_i is high; result uses the state after it.
// Depends on crd_pkg.
module crd_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  crd_pkg::crd_cfg_t  cfg_i,
  input  logic               fire_i,
  input  crd_pkg::crd_in_t   item_i,
  output crd_pkg::crd_out_t  res_o
);

  crd_pkg::phase_e phase_q, phase_d;
  logic [63:0]     deadline_q, deadline_d;

  logic        upd;
  logic [31:0] dly;
  logic        app_on;
  logic [64:0] sum;
  logic        ovf;
  logic [31:0] left_set;
  logic [64:0] diff;
  logic        reached_hold;
  logic [31:0] left_hold;
  logic        reached;
  logic [31:0] left_raw;

  assign app_on = (cfg_i.application_timeout != 32'd0);

  // Next phase and which delay, if any, sets the new deadline.
  always_comb begin
    phase_d = phase_q;
    upd     = 1'b0;
    dly     = cfg_i.connect_timeout;
    case (crd_pkg::func_e'(item_i.func))
      crd_pkg::FN_ATTEMPT: begin
        phase_d = crd_pkg::PH_CONNECTING;
        upd     = 1'b1;
        dly     = cfg_i.connect_timeout;
      end
      crd_pkg::FN_TRANSPORT: begin
        if (app_on) begin
          phase_d = crd_pkg::PH_AWAITING;
          upd     = 1'b1;
        end
        dly = cfg_i.application_timeout;
      end
      crd_pkg::FN_ALIVE: begin
        upd = app_on && (phase_q == crd_pkg::PH_CONNECTED);
        dly = cfg_i.application_timeout;
      end
      crd_pkg::FN_READY: begin
        if (app_on) begin
          phase_d = crd_pkg::PH_CONNECTED;
          upd     = 1'b1;
        end
        dly = cfg_i.application_timeout;
      end
      crd_pkg::FN_FAILED: begin
        phase_d = crd_pkg::PH_WAITING;
        upd     = 1'b1;
        dly     = cfg_i.retry_delay;
      end
      default: ;
    endcase
  end

  // Saturating deadline sum. When it saturates, the distance left is the
  // complement of the current time, which is below the delay.
  assign sum        = {1'b0, item_i.now_time} + {33'd0, dly};
  assign ovf        = sum[64];
  assign deadline_d = upd ? (ovf ? {64{1'b1}} : sum[63:0]) : deadline_q;
  assign left_set   = ovf ? ~item_i.now_time[31:0] : dly;

  // Distance to an unchanged deadline, computed alongside the sum.
  assign diff         = {1'b0, deadline_q} - {1'b0, item_i.now_time};
  assign reached_hold = diff[64] || (diff[63:0] == 64'd0);
  assign left_hold    = (diff[63:32] != 32'd0) ? {32{1'b1}} : diff[31:0];

  assign reached  = upd ? (left_set == 32'd0) : reached_hold;
  assign left_raw = upd ? left_set : left_hold;

  // Result fields from the phase after the event.
  always_comb begin
    res_o.phase_now           = phase_d;
    res_o.may_start           = 1'b0;
    res_o.attempt_expired     = 1'b0;
    res_o.application_expired = 1'b0;
    res_o.wait_left           = 32'd0;
    case (phase_d)
      crd_pkg::PH_READY: begin
        res_o.may_start = 1'b1;
      end
      crd_pkg::PH_CONNECTING: begin
        res_o.attempt_expired = reached;
        res_o.wait_left       = reached ? 32'd0 : left_raw;
      end
      crd_pkg::PH_AWAITING, crd_pkg::PH_CONNECTED: begin
        res_o.application_expired = reached;
        res_o.wait_left           = {32{1'b1}};
      end
      crd_pkg::PH_WAITING: begin
        res_o.may_start = reached;
        res_o.wait_left = reached ? 32'd0 : left_raw;
      end
      default: ;
    endcase
  end

  // State update when a transaction moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= crd_pkg::PH_READY;
      deadline_q <= 64'd0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      deadline_q <= deadline_d;
    end
  end

endmodule

/* sv/connect_retry_deadline_fsm.sv */
// Connection retry deadline supervisor: input register, event core and result
// register. Depends on crd_pkg, crd_cfg_regs and crd_core.
//
// Usage:
//   Input transactions (in_data_i: event code and current time in ms) are
//   accepted on a rising edge with in_valid_i high and in_stall_o low.
//   Every input transaction yields exactly one result transaction on
//   out_data_o, taken on an edge with out_valid_o high and out_stall_i low.
//   After acceptance the transaction sits in the input register, then the
//   phase/deadline update and result forming load the result register.
//   Throughput is one transaction per cycle while the receiver does not
//   stall, set by the combinational saturating 64-bit add and compare in
//   the core. When the receiver stalls, the result register holds its
//   value and the input register fills; in_stall_o rises once both are
//   occupied and the stall persists. Configuration registers are written
//   through cfg_we_i, cfg_idx_i and cfg_wdata_i; unknown indexes are
//   ignored. The user must write them only while the block is idle; the
//   block itself does not enforce this. Reset empties both pipeline
//   registers, sets the phase to ready with a zero deadline and loads the
//   register defaults.
module connect_retry_deadline_fsm (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  crd_pkg::crd_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output crd_pkg::crd_out_t            out_data_o,
  input  logic                         cfg_we_i,
  input  logic [crd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                  cfg_wdata_i
);

  crd_pkg::crd_cfg_t cfg;
  crd_pkg::crd_in_t  s1_data_q;
  logic              s1_valid_q;
  crd_pkg::crd_out_t out_data_q;
  logic              out_valid_q;
  crd_pkg::crd_out_t res;
  logic              advance;
  logic              fire;
  logic              in_take;

  crd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Pipeline handshake: the result register frees when empty or taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  crd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (fire),
    .item_i (s1_data_q),
    .res_o  (res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance || !s1_valid_q) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_data_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* sv/crd_checker.sv */
// Port-level checker for the connection retry deadline block, with its bind.
// Depends on crd_pkg and connect_retry_deadline_fsm.
module crd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input crd_pkg::crd_out_t out_data_o
);

  // A stalled result transaction holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Ready phase always permits a start with no wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.phase_now == crd_pkg::PH_READY) |->
      out_data_o.may_start && (out_data_o.wait_left == 32'd0))
    else $error("ready result inconsistent");

  // Application phases report a full wait and no start or attempt expiry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.phase_now == crd_pkg::PH_AWAITING) ||
                    (out_data_o.phase_now == crd_pkg::PH_CONNECTED)) |->
      (out_data_o.wait_left == 32'hFFFF_FFFF) && !out_data_o.may_start &&
      !out_data_o.attempt_expired)
    else $error("application phase result inconsistent");

  // While connecting, expiry coincides with no time left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.phase_now == crd_pkg::PH_CONNECTING) |->
      (out_data_o.attempt_expired == (out_data_o.wait_left == 32'd0)) &&
      !out_data_o.may_start)
    else $error("connecting result inconsistent");

  // While waiting, a start is permitted exactly when no time is left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.phase_now == crd_pkg::PH_WAITING) |->
      (out_data_o.may_start == (out_data_o.wait_left == 32'd0)) &&
      !out_data_o.application_expired)
    else $error("waiting result inconsistent");

endmodule

bind connect_retry_deadline_fsm crd_checker u_crd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* dv/tb_top.sv */
// Testbench for connect_retry_deadline_fsm: directed and random event streams
// with random idling on both channels, checked against an in-bench predictor.
// Depends on crd_pkg and the connect_retry_deadline_fsm RTL.
module tb_top;

  localparam int unsigned IdleLimit     = 1000;
  localparam int unsigned HoldOffCycles = 40;
  localparam logic [63:0] TimeMax       = '1;
  localparam logic [31:0] DelayMax      = '1;

  // Event codes outside the defined set; the block treats them as a query.
  localparam logic [2:0] FN_SPARE_A = 3'd6;
  localparam logic [2:0] FN_SPARE_B = 3'd7;

  // Mirrors the phase, deadline and delay registers and keeps the reports
  // still owed by the block, oldest first.
  class deadline_scoreboard;
    crd_pkg::phase_e   phase_q;
    logic [63:0]       deadline_q;
    logic [31:0]       retry_ms;
    logic [31:0]       connect_ms;
    logic [31:0]       app_ms;
    crd_pkg::crd_out_t due_reports[$];
    int unsigned       mismatches;

    function new();
      phase_q    = crd_pkg::PH_READY;
      deadline_q = '0;
      retry_ms   = crd_pkg::RETRY_DELAY_RST;
      connect_ms = crd_pkg::CONNECT_TIMEOUT_RST;
      app_ms     = crd_pkg::APP_TIMEOUT_RST;
      mismatches = 0;
    endfunction

    // Deadline from now plus a delay, pinned at all ones on overflow.
    function logic [63:0] push_out(logic [63:0] now, logic [31:0] delay);
      logic [64:0] sum;
      sum = {1'b0, now} + {33'd0, delay};
      return sum[64] ? TimeMax : sum[63:0];
    endfunction

    function void set_register(logic [crd_pkg::CfgIdxW-1:0] idx, logic [31:0] value);
      case (idx)
        crd_pkg::CFG_RETRY_DELAY:     retry_ms = value;
        crd_pkg::CFG_CONNECT_TIMEOUT: connect_ms = value;
        crd_pkg::CFG_APP_TIMEOUT:     app_ms = value;
        default: ;
      endcase
    endfunction

    // Applies one accepted event and queues the report it must produce.
    function void note_event(crd_pkg::crd_in_t ev);
      crd_pkg::crd_out_t rep;
      logic              reached;
      logic [63:0]       gap;
      case (ev.func)
        crd_pkg::FN_ATTEMPT: begin
          phase_q    = crd_pkg::PH_CONNECTING;
          deadline_q = push_out(ev.now_time, connect_ms);
        end
        crd_pkg::FN_TRANSPORT: begin
          if (app_ms != 0) begin
            phase_q    = crd_pkg::PH_AWAITING;
            deadline_q = push_out(ev.now_time, app_ms);
          end
        end
        crd_pkg::FN_ALIVE: begin
          if (app_ms != 0 && phase_q == crd_pkg::PH_CONNECTED) begin
            deadline_q = push_out(ev.now_time, app_ms);
          end
        end
        crd_pkg::FN_READY: begin
          if (app_ms != 0) begin
            phase_q    = crd_pkg::PH_CONNECTED;
            deadline_q = push_out(ev.now_time, app_ms);
          end
        end
        crd_pkg::FN_FAILED: begin
          phase_q    = crd_pkg::PH_WAITING;
          deadline_q = push_out(ev.now_time, retry_ms);
        end
        default: ;
      endcase

      reached                 = ev.now_time >= deadline_q;
      gap                     = deadline_q - ev.now_time;
      rep.phase_now           = phase_q;
      rep.may_start           = (phase_q == crd_pkg::PH_READY) ||
                                (phase_q == crd_pkg::PH_WAITING && reached);
      rep.attempt_expired     = (phase_q == crd_pkg::PH_CONNECTING) && reached;
      rep.application_expired = (phase_q == crd_pkg::PH_AWAITING ||
                                 phase_q == crd_pkg::PH_CONNECTED) && reached;
      if (phase_q == crd_pkg::PH_READY) begin
        rep.wait_left = '0;
      end else if (phase_q == crd_pkg::PH_AWAITING || phase_q == crd_pkg::PH_CONNECTED) begin
        rep.wait_left = '1;
      end else if (reached) begin
        rep.wait_left = '0;
      end else if (gap[63:32] != 0) begin
        rep.wait_left = '1;
      end else begin
        rep.wait_left = gap[31:0];
      end
      due_reports.push_back(rep);
    endfunction

    // Compares one accepted result transaction with the oldest report owed.
    function void check_report(crd_pkg::crd_out_t got);
      crd_pkg::crd_out_t want;
      if (due_reports.size() == 0) begin
        $error("result transaction with none pending: phase_now %0d wait_left %0d",
               got.phase_now, got.wait_left);
        mismatches++;
        return;
      end
      want = due_reports.pop_front();
      if (got.phase_now !== want.phase_now) begin
        $error("phase_now: expected %0d, actual %0d", want.phase_now, got.phase_now);
        mismatches++;
      end
      if (got.may_start !== want.may_start) begin
        $error("may_start: expected %0d, actual %0d", want.may_start, got.may_start);
        mismatches++;
      end
      if (got.attempt_expired !== want.attempt_expired) begin
        $error("attempt_expired: expected %0d, actual %0d",
               want.attempt_expired, got.attempt_expired);
        mismatches++;
      end
      if (got.application_expired !== want.application_expired) begin
        $error("application_expired: expected %0d, actual %0d",
               want.application_expired, got.application_expired);
        mismatches++;
      end
      if (got.wait_left !== want.wait_left) begin
        $error("wait_left: expected %0d, actual %0d", want.wait_left, got.wait_left);
        mismatches++;
      end
    endfunction
  endclass

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  crd_pkg::crd_in_t            in_data   = '0;
  logic                        out_stall = 1'b0;
  logic                        cfg_we    = 1'b0;
  logic [crd_pkg::CfgIdxW-1:0] cfg_idx   = '0;
  logic [31:0]                 cfg_wdata = '0;
  logic                        in_stall;
  logic                        out_valid;
  crd_pkg::crd_out_t           out_data;

  deadline_scoreboard sb = new();

  bit          calm         = 1'b0;
  bit          hold_off_req = 1'b0;
  logic [63:0] t_now        = '0;
  int unsigned idle_cycles  = 0;

  connect_retry_deadline_fsm dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Ends the run when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: random stall before each transaction, with an occasional
  // long hold-off so that the block backs up into its input.
  initial begin : result_sink
    int unsigned stall_len;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_len    = HoldOffCycles;
      end else begin
        stall_len = calm ? 0 : $urandom_range(0, 3);
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_report(out_data);
    end
  end

  // Offers one event after a random gap and waits until it is taken.
  task automatic send_event(input logic [2:0] func, input logic [63:0] now);
    int unsigned      gap;
    crd_pkg::crd_in_t ev;
    gap         = calm ? 0 : $urandom_range(0, 3);
    ev.func     = func;
    ev.now_time = now;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall);
    sb.note_event(ev);
  endtask

  // Stops offering and waits until every owed report has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.due_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes all three delay registers on consecutive cycles once idle.
  task automatic load_delays(input logic [31:0] retry, input logic [31:0] connect,
                             input logic [31:0] app);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= crd_pkg::CFG_RETRY_DELAY;
    cfg_wdata <= retry;
    @(posedge clk);
    cfg_idx   <= crd_pkg::CFG_CONNECT_TIMEOUT;
    cfg_wdata <= connect;
    @(posedge clk);
    cfg_idx   <= crd_pkg::CFG_APP_TIMEOUT;
    cfg_wdata <= app;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(crd_pkg::CFG_RETRY_DELAY, retry);
    sb.set_register(crd_pkg::CFG_CONNECT_TIMEOUT, connect);
    sb.set_register(crd_pkg::CFG_APP_TIMEOUT, app);
  endtask

  // Mostly plausible connection lifecycles on a moving clock, plus noise.
  task automatic run_random(input int unsigned count);
    logic [2:0]  func;
    logic [63:0] now;
    int unsigned r;
    repeat (count) begin
      if ($urandom_range(0, 99) < 80) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: t_now += 64'($urandom_range(0, 12000));
          12, 13:                                t_now += 64'($urandom_range(0, 3));
          14, 15, 16, 17:                        t_now += {32'd0, $urandom()};
          18:                                    t_now = TimeMax - 64'($urandom_range(0, 20000));
          default:                               t_now = 64'($urandom_range(0, 100000));
        endcase
        now = t_now;
        r   = $urandom_range(0, 5);
        case (sb.phase_q)
          crd_pkg::PH_READY: begin
            func = (r < 2) ? crd_pkg::FN_QUERY : crd_pkg::FN_ATTEMPT;
          end
          crd_pkg::PH_CONNECTING: begin
            func = (r == 0) ? crd_pkg::FN_QUERY :
                   (r == 1) ? crd_pkg::FN_FAILED : crd_pkg::FN_TRANSPORT;
          end
          crd_pkg::PH_AWAITING: begin
            func = (r == 0) ? crd_pkg::FN_QUERY :
                   (r == 1) ? crd_pkg::FN_FAILED :
                   (r == 2) ? crd_pkg::FN_ALIVE : crd_pkg::FN_READY;
          end
          crd_pkg::PH_CONNECTED: begin
            func = (r < 2)  ? crd_pkg::FN_ALIVE :
                   (r == 2) ? crd_pkg::FN_QUERY :
                   (r == 3) ? crd_pkg::FN_FAILED : crd_pkg::FN_READY;
          end
          default: begin
            func = (r < 2) ? crd_pkg::FN_QUERY : crd_pkg::FN_ATTEMPT;
          end
        endcase
      end else begin
        func = 3'($urandom_range(0, 7));
        now  = {$urandom(), $urandom()};
      end
      send_event(func, now);
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset delays: every event, both sides of each deadline, spare codes,
    // ignored alive, saturation of the deadline and of the remaining wait.
    send_event(crd_pkg::FN_QUERY, 64'd0);
    send_event(FN_SPARE_A, 64'd5);
    send_event(FN_SPARE_B, 64'd9);
    send_event(crd_pkg::FN_ALIVE, 64'd10);
    send_event(crd_pkg::FN_ATTEMPT, 64'd100);
    send_event(crd_pkg::FN_QUERY, 64'd5099);
    send_event(crd_pkg::FN_QUERY, 64'd5100);
    send_event(crd_pkg::FN_TRANSPORT, 64'd5200);
    send_event(crd_pkg::FN_ALIVE, 64'd6000);
    send_event(crd_pkg::FN_QUERY, 64'd15200);
    send_event(crd_pkg::FN_READY, 64'd15300);
    send_event(crd_pkg::FN_ALIVE, 64'd20000);
    send_event(crd_pkg::FN_QUERY, 64'd29999);
    send_event(crd_pkg::FN_FAILED, 64'd30001);
    send_event(crd_pkg::FN_QUERY, 64'd31000);
    send_event(crd_pkg::FN_QUERY, 64'd31001);
    send_event(crd_pkg::FN_ATTEMPT, 64'h0000_0100_0000_0000);
    send_event(crd_pkg::FN_QUERY, 64'd0);
    send_event(crd_pkg::FN_ATTEMPT, TimeMax - 64'd100);
    send_event(crd_pkg::FN_QUERY, TimeMax);
    send_event(crd_pkg::FN_FAILED, TimeMax);
    send_event(crd_pkg::FN_TRANSPORT, TimeMax - 64'd1);
    send_event(crd_pkg::FN_READY, TimeMax);
    send_event(crd_pkg::FN_ALIVE, 64'h5555_AAAA_5555_AAAA);
    send_event(crd_pkg::FN_QUERY, 64'hAAAA_5555_AAAA_5555);
    t_now = '0;
    run_random(80);

    // Zero delays: application events are dropped and deadlines land on now.
    load_delays(32'd0, 32'd0, 32'd0);
    send_event(crd_pkg::FN_TRANSPORT, 64'd50);
    send_event(crd_pkg::FN_ALIVE, 64'd55);
    send_event(crd_pkg::FN_READY, 64'd60);
    send_event(crd_pkg::FN_ATTEMPT, 64'd70);
    send_event(crd_pkg::FN_FAILED, 64'd80);
    run_random(60);

    // Shortest nonzero and longest delays.
    load_delays(32'd1, 32'd1, 32'd1);
    run_random(70);
    load_delays(DelayMax, DelayMax, DelayMax);
    run_random(80);

    // Mid-range delays with back-pressure and a stretch without idling.
    load_delays($urandom_range(1, 20000), $urandom_range(1, 20000),
                $urandom_range(1, 20000));
    hold_off_req = 1'b1;
    run_random(60);
    calm = 1'b1;
    run_random(40);
    calm         = 1'b0;
    hold_off_req = 1'b1;
    run_random(40);

    settle();
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
